[rtl/bencode_to_text_transducer_macros.svh]
// Assertion macros shared by the bencode transducer checker.
// Needs no other file; each macro expands to one labeled concurrent assertion.
`ifndef BENCODE_TO_TEXT_TRANSDUCER_MACROS_SVH
`define BENCODE_TO_TEXT_TRANSDUCER_MACROS_SVH

// Overlapping implication: when ante holds, cons must hold in the same cycle.
`define BTT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bencode transducer check failed");

// Non-overlapping implication: when ante holds, cons must hold in the next cycle.
`define BTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bencode transducer check failed");

`endif

[rtl/btt_pkg.sv]
// Shared types, character codes and helper functions for the bencode transducer.
// Has no dependencies; imported by the top level and by its checker.
`default_nettype none

package btt_pkg;

   localparam int DEFAULT_MAX_DEPTH   = 16;
   localparam int DEFAULT_LENGTH_BITS = 24;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_I      = 8'h69;
   localparam logic [7:0] CHAR_L      = 8'h6c;
   localparam logic [7:0] CHAR_D      = 8'h64;
   localparam logic [7:0] CHAR_COLON  = 8'h3a;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_LBRACK = 8'h5b;
   localparam logic [7:0] CHAR_RBRACK = 8'h5d;
   localparam logic [7:0] CHAR_LBRACE = 8'h7b;
   localparam logic [7:0] CHAR_RBRACE = 8'h7d;
   localparam logic [7:0] CHAR_MINUS  = 8'h2d;

   localparam logic KIND_TEXT  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   localparam logic CONT_LIST = 1'b0;
   localparam logic CONT_DICT = 1'b1;

   localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
   localparam logic [1:0] ERR_TOO_DEEP   = 2'd1;
   localparam logic [1:0] ERR_LENGTH     = 2'd2;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [1:0] error_code;
      logic       last;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic result_type text_result(input logic [7:0] b, input logic fin);
      result_type r;
      r.kind       = KIND_TEXT;
      r.out_byte   = b;
      r.error_code = ERR_UNEXPECTED;
      r.last       = fin;
      return r;
   endfunction

   function automatic result_type error_result(input logic [1:0] code);
      result_type r;
      r.kind       = KIND_ERROR;
      r.out_byte   = 8'h00;
      r.error_code = code;
      r.last       = 1'b1;
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/bencode_to_text_transducer.sv]
// Top level of the bencode-to-text transducer: input register, decoder, result queue.
// Depends on btt_pkg for character codes, result type and helper functions.
`default_nettype none

// The block takes one bencoded byte per request and renders it as text: integer digits and
// minus signs pass through, strings come out between double quotes, lists as brackets and
// dictionaries as braces. A byte is registered, decoded once the queue has room, and its
// results (zero, one or two) are written into a four-entry result queue that feeds the
// result channel. A new byte is accepted in every cycle as long as the queue has room for
// two results; the sustained rate is one byte per cycle, limited only by the result channel,
// which delivers one result per cycle; an empty string and the final byte of a string both
// give two results. After any error the block sends one error result and then consumes
// bytes without producing anything until reset.
module bencode_to_text_transducer
   import btt_pkg::*;
#(
   parameter int MAX_DEPTH   = DEFAULT_MAX_DEPTH,
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   // Result channel.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] out_byte, [9:8] error_code, zeros above
   output      logic                  rsp_tuser,   // [0] kind: 0 text, 1 error
   output      logic                  rsp_tlast    // final result caused by one request
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_VALUE,
      MODE_INT,
      MODE_LEN,
      MODE_DATA,
      MODE_HALT
   } mode_type;

   // Input register.
   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;

   // Decoder state.
   mode_type               mode_ff, mode_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [DEPTH_W-1:0]     depth_ff;
   logic                   stack_ff [MAX_DEPTH];

   // Result queue.
   result_type             fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  count_ff;

   logic                   consume;
   logic                   rsp_pop;
   logic [1:0]             n_res;
   result_type             res0, res1;
   logic                   push, pop, push_kind;
   logic [3:0]             digit;
   logic [LENGTH_BITS+3:0] len_x10;
   logic                   depth_full;

   // The queue must hold two more results before a registered byte is decoded.
   assign consume    = in_valid_ff && (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || consume;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   assign rsp_tdata  = {{(RSP_DATA_W - 10){1'b0}}, fifo_ff[rd_ptr_ff].error_code,
                        fifo_ff[rd_ptr_ff].out_byte};
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

   // ASCII digits carry their value in the low nibble.
   assign digit      = in_byte_ff[3:0];
   assign len_x10    = ({4'b0000, len_ff} << 3) + ({4'b0000, len_ff} << 1)
                       + {{LENGTH_BITS{1'b0}}, digit};
   assign depth_full = (depth_ff == DEPTH_W'(MAX_DEPTH));

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      n_res     = 2'd0;
      res0      = text_result(8'h00, 1'b0);
      res1      = text_result(CHAR_QUOTE, 1'b1);
      push      = 1'b0;
      pop       = 1'b0;
      push_kind = CONT_LIST;
      unique case (mode_ff)
         MODE_VALUE: begin
            if (in_byte_ff == CHAR_I) begin
               mode_in = MODE_INT;
            end else if (is_digit(in_byte_ff)) begin
               len_in  = LENGTH_BITS'(digit);
               mode_in = MODE_LEN;
            end else if (in_byte_ff == CHAR_L || in_byte_ff == CHAR_D) begin
               n_res = 2'd1;
               if (depth_full) begin
                  res0    = error_result(ERR_TOO_DEEP);
                  mode_in = MODE_HALT;
               end else begin
                  push      = 1'b1;
                  push_kind = (in_byte_ff == CHAR_D) ? CONT_DICT : CONT_LIST;
                  res0      = text_result((in_byte_ff == CHAR_D) ? CHAR_LBRACE : CHAR_LBRACK,
                                          1'b1);
               end
            end else if (in_byte_ff == CHAR_E && depth_ff != '0) begin
               pop   = 1'b1;
               n_res = 2'd1;
               res0  = text_result((stack_ff[0] == CONT_DICT) ? CHAR_RBRACE : CHAR_RBRACK,
                                   1'b1);
            end else begin
               n_res   = 2'd1;
               res0    = error_result(ERR_UNEXPECTED);
               mode_in = MODE_HALT;
            end
         end
         MODE_INT: begin
            if (in_byte_ff == CHAR_E) begin
               mode_in = MODE_VALUE;
            end else if (is_digit(in_byte_ff) || in_byte_ff == CHAR_MINUS) begin
               n_res = 2'd1;
               res0  = text_result(in_byte_ff, 1'b1);
            end else begin
               n_res   = 2'd1;
               res0    = error_result(ERR_UNEXPECTED);
               mode_in = MODE_HALT;
            end
         end
         MODE_LEN: begin
            if (is_digit(in_byte_ff)) begin
               if (len_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000) begin
                  n_res   = 2'd1;
                  res0    = error_result(ERR_LENGTH);
                  mode_in = MODE_HALT;
               end else begin
                  len_in = len_x10[LENGTH_BITS-1:0];
               end
            end else if (in_byte_ff == CHAR_COLON) begin
               if (len_ff == '0) begin
                  // Empty string: both quotes come out for the colon.
                  n_res   = 2'd2;
                  res0    = text_result(CHAR_QUOTE, 1'b0);
                  mode_in = MODE_VALUE;
               end else begin
                  n_res   = 2'd1;
                  res0    = text_result(CHAR_QUOTE, 1'b1);
                  mode_in = MODE_DATA;
               end
            end else begin
               n_res   = 2'd1;
               res0    = error_result(ERR_UNEXPECTED);
               mode_in = MODE_HALT;
            end
         end
         MODE_DATA: begin
            len_in = len_ff - 1'b1;
            if (len_ff == LENGTH_BITS'(1)) begin
               // Final data byte also closes the quote.
               n_res   = 2'd2;
               res0    = text_result(in_byte_ff, 1'b0);
               mode_in = MODE_VALUE;
            end else begin
               n_res = 2'd1;
               res0  = text_result(in_byte_ff, 1'b1);
            end
         end
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         default: begin
            mode_in = MODE_HALT;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_VALUE;
         len_ff      <= '0;
         depth_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (consume) begin
            mode_ff <= mode_in;
            len_ff  <= len_in;
            if (push) begin
               depth_ff <= depth_ff + 1'b1;
            end else if (pop) begin
               depth_ff <= depth_ff - 1'b1;
            end
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(n_res);
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (consume ? FIFO_CNT_W'(n_res) : '0)
                     - FIFO_CNT_W'(rsp_pop);
      end
   end

   // Payload: input byte, queue entries and the container stack (top at entry zero).
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (consume && n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (consume && n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + 1'b1] <= res1;
      end
      if (consume && push) begin
         stack_ff[0] <= push_kind;
         for (int i = 1; i < MAX_DEPTH; i++) begin
            stack_ff[i] <= stack_ff[i-1];
         end
      end else if (consume && pop) begin
         for (int i = 0; i < MAX_DEPTH - 1; i++) begin
            stack_ff[i] <= stack_ff[i+1];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/btt_checker.sv]
// Port-level checker for the bencode transducer, bound to the top level.
// Depends on btt_pkg and bencode_to_text_transducer_macros.svh.
`default_nettype none

`include "bencode_to_text_transducer_macros.svh"

module btt_checker
   import btt_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser,
   input wire logic                  rsp_tlast
);

   // A waiting result is not withdrawn.
   `BTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // An error report always ends the results of its request.
   `BTT_ASSERT_SAME(a_err_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)

   // An error report carries no text byte.
   `BTT_ASSERT_SAME(a_err_byte, clock, reset, rsp_tvalid && rsp_tuser,
                    rsp_tdata[7:0] == 8'h00)

   // A text result carries no error code.
   `BTT_ASSERT_SAME(a_text_code, clock, reset, rsp_tvalid && !rsp_tuser,
                    rsp_tdata[9:8] == ERR_UNEXPECTED)

   // Once the error report is taken, the block has halted and sends nothing more.
   `BTT_ASSERT_NEXT(a_halt, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser,
                    !rsp_tvalid)

endmodule

bind bencode_to_text_transducer btt_checker u_btt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[test/bencode_text_checker.sv]
`timescale 1ns / 100ps
// Checker for the bencode-to-text transducer: predicts the text and error results of
// every accepted request and compares them with the result channel. Depends on btt_pkg.
module bencode_text_checker
   import btt_pkg::*;
#(
   parameter int MAX_DEPTH   = DEFAULT_MAX_DEPTH,
   parameter int LENGTH_BITS = DEFAULT_LENGTH_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] in_byte
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] out_byte, [9:8] error_code
   input  wire logic                  rsp_tuser,   // [0] kind
   input  wire logic                  rsp_tlast,
   output int unsigned                mismatches,
   output int unsigned                pending_results
);

   typedef enum logic [2:0] {
      AWAIT_VALUE,
      IN_INTEGER,
      IN_LENGTH,
      IN_DATA,
      HALTED
   } parse_mode_type;

   localparam logic [7:0] CHAR_ZERO = "0";
   localparam logic [7:0] CHAR_NINE = "9";
   localparam longint unsigned LENGTH_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;

   parse_mode_type         parse_mode;
   logic [LENGTH_BITS-1:0] string_left;
   int unsigned            open_count;
   logic [MAX_DEPTH-1:0]   open_kinds;
   result_type             rendered_q[$];

   function automatic logic decimal_char(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic void push_text(input logic [7:0] b, input logic fin);
      rendered_q.push_back('{kind: KIND_TEXT, out_byte: b, error_code: 2'b00, last: fin});
   endfunction

   function automatic void halt_with(input logic [1:0] code);
      rendered_q.push_back('{kind: KIND_ERROR, out_byte: 8'h00, error_code: code, last: 1'b1});
      parse_mode = HALTED;
   endfunction

   function automatic void open_container(input logic kind, input logic [7:0] sym);
      if (open_count >= MAX_DEPTH) begin
         halt_with(ERR_TOO_DEEP);
      end else begin
         open_kinds[open_count] = kind;
         open_count++;
         push_text(sym, 1'b1);
      end
   endfunction

   // Works out the results that one request byte causes and advances the parse state.
   function automatic void render_byte(input logic [7:0] b);
      longint unsigned grown;
      case (parse_mode)
         AWAIT_VALUE: begin
            if (b == CHAR_I) begin
               parse_mode = IN_INTEGER;
            end else if (decimal_char(b)) begin
               string_left = LENGTH_BITS'(b - CHAR_ZERO);
               parse_mode  = IN_LENGTH;
            end else if (b == CHAR_L) begin
               open_container(CONT_LIST, CHAR_LBRACK);
            end else if (b == CHAR_D) begin
               open_container(CONT_DICT, CHAR_LBRACE);
            end else if (b == CHAR_E && open_count > 0) begin
               open_count--;
               push_text((open_kinds[open_count] == CONT_DICT) ? CHAR_RBRACE : CHAR_RBRACK,
                         1'b1);
            end else begin
               halt_with(ERR_UNEXPECTED);
            end
         end
         IN_INTEGER: begin
            if (b == CHAR_E) begin
               parse_mode = AWAIT_VALUE;
            end else if (decimal_char(b) || b == CHAR_MINUS) begin
               push_text(b, 1'b1);
            end else begin
               halt_with(ERR_UNEXPECTED);
            end
         end
         IN_LENGTH: begin
            if (decimal_char(b)) begin
               grown = 64'(string_left) * 64'd10 + 64'(b - CHAR_ZERO);
               if (grown > LENGTH_LIMIT) begin
                  halt_with(ERR_LENGTH);
               end else begin
                  string_left = grown[LENGTH_BITS-1:0];
               end
            end else if (b == CHAR_COLON) begin
               if (string_left == '0) begin
                  push_text(CHAR_QUOTE, 1'b0);
                  push_text(CHAR_QUOTE, 1'b1);
                  parse_mode = AWAIT_VALUE;
               end else begin
                  push_text(CHAR_QUOTE, 1'b1);
                  parse_mode = IN_DATA;
               end
            end else begin
               halt_with(ERR_UNEXPECTED);
            end
         end
         IN_DATA: begin
            string_left = string_left - 1'b1;
            if (string_left == '0) begin
               push_text(b, 1'b0);
               push_text(CHAR_QUOTE, 1'b1);
               parse_mode = AWAIT_VALUE;
            end else begin
               push_text(b, 1'b1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Results are compared before the request of the same edge is predicted, since a
   // result can never belong to a byte accepted at that very edge.
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         parse_mode  = AWAIT_VALUE;
         string_left = '0;
         open_count  = 0;
         open_kinds  = '0;
         rendered_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = '{kind: rsp_tuser, out_byte: rsp_tdata[7:0], error_code: rsp_tdata[9:8],
                     last: rsp_tlast};
            if (rendered_q.size() == 0) begin
               $display("%0t: result with none expected: kind=%0d byte=%02h code=%0d last=%0d",
                        $realtime, seen.kind, seen.out_byte, seen.error_code, seen.last);
               mismatches++;
            end else begin
               want = rendered_q.pop_front();
               if (seen !== want) begin
                  $display("%0t: expected kind=%0d byte=%02h code=%0d last=%0d,",
                           $realtime, want.kind, want.out_byte, want.error_code, want.last,
                           " got kind=%0d byte=%02h code=%0d last=%0d",
                           seen.kind, seen.out_byte, seen.error_code, seen.last);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            render_byte(req_tdata[7:0]);
         end
      end
      pending_results = rendered_q.size();
   end

endmodule

[test/bencode_to_text_transducer_tb.sv]
`timescale 1ns / 100ps
// Top of the bencode-to-text transducer testbench: builds the request stream, drives both
// channels and gives the verdict. Depends on btt_pkg, the transducer and bencode_text_checker.
module bencode_to_text_transducer_tb;
   import btt_pkg::*;

   localparam logic [7:0] CHAR_ZERO = "0";
   localparam int unsigned RANDOM_BYTES = 1130;
   localparam int unsigned DRAIN_LIMIT  = 5000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned RUN_LIMIT_NS = 1_000_000;

   typedef enum int unsigned {ALWAYS_READY, COIN_READY, RUN_READY} stall_style_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;      // [7:0] in_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;            // [7:0] out_byte, [9:8] error_code
   logic                  rsp_tuser;            // [0] kind: 0 text, 1 error
   logic                  rsp_tlast;
   int unsigned           mismatches;
   int unsigned           pending_results;

   // Every byte that will be offered on the request channel, in order.
   logic [7:0] request_bytes[$];

   always #1 clock = ~clock;

   bencode_to_text_transducer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   bencode_text_checker u_text_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatches      (mismatches),
      .pending_results (pending_results)
   );

   task automatic append_text(input string s);
      for (int k = 0; k < s.len(); k++) begin
         request_bytes.push_back(s[k]);
      end
   endtask

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   task automatic append_integer();
      int unsigned digits;
      digits = $urandom_range(0, 6);
      request_bytes.push_back(CHAR_I);
      // Signs are not checked by the block, so doubled and misplaced minus signs
      // must pass through just as well as a single leading one.
      case ($urandom_range(0, 5))
         0, 1: request_bytes.push_back(CHAR_MINUS);
         2: begin
            request_bytes.push_back(CHAR_MINUS);
            request_bytes.push_back(CHAR_MINUS);
         end
         default: begin
         end
      endcase
      repeat (digits) request_bytes.push_back(random_digit());
      if ($urandom_range(0, 9) == 0) begin
         request_bytes.push_back(CHAR_MINUS);
      end
      request_bytes.push_back(CHAR_E);
   endtask

   // A string with a mostly short length, sometimes leading zeros, and raw data that
   // covers the whole byte range, quotes and bencode markers included.
   task automatic append_string();
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 2)) request_bytes.push_back(CHAR_ZERO);
      end
      append_text($sformatf("%0d", len));
      request_bytes.push_back(CHAR_COLON);
      repeat (len) request_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic append_open();
      request_bytes.push_back($urandom_range(0, 1) ? CHAR_D : CHAR_L);
   endtask

   // Short hand-picked documents: a negative integer with a leading zero, an empty integer,
   // an empty string, leading zeros with extreme and quote data bytes, and a dictionary inside a list.
   task automatic append_directed();
      append_text("i-09e");
      append_text("ie");
      append_text("0:");
      append_text("03:");
      request_bytes.push_back(8'h00);
      request_bytes.push_back(8'hff);
      request_bytes.push_back(CHAR_QUOTE);
      append_text("ldi7e0:ee");
   endtask

   // Well-formed random documents. Now and then the nesting dives to the full stack
   // depth; every container is closed before the stream ends.
   task automatic build_document_stream(input int unsigned target);
      int unsigned open_levels;
      int unsigned pick;
      open_levels = 0;
      while (request_bytes.size() < target || open_levels > 0) begin
         pick = $urandom_range(0, 99);
         if (request_bytes.size() >= target) begin
            pick = 30;
         end
         if (open_levels == 0 && $urandom_range(0, 29) == 0) begin
            while (open_levels < DEFAULT_MAX_DEPTH) begin
               append_open();
               open_levels++;
               if ($urandom_range(0, 3) == 0) append_integer();
            end
         end else if (pick < 22 && open_levels < DEFAULT_MAX_DEPTH) begin
            append_open();
            open_levels++;
         end else if (pick < 45 && open_levels > 0) begin
            request_bytes.push_back(CHAR_E);
            open_levels--;
         end else if (pick < 70) begin
            append_integer();
         end else begin
            append_string();
         end
      end
   endtask

   // The block halts for good on its first error and reset is applied only once, so each
   // run ends on one randomly chosen error, followed by bytes that must all be ignored.
   task automatic append_breaking_tail();
      logic [7:0] b;
      case ($urandom_range(0, 4))
         0: begin
            // Stray byte where a value should start; with nothing open an 'e' is one too.
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_I || b == CHAR_L || b == CHAR_D ||
                   (b >= CHAR_ZERO && b <= "9"));
            request_bytes.push_back(b);
         end
         1: begin
            // Bad byte inside an integer.
            request_bytes.push_back(CHAR_I);
            repeat ($urandom_range(0, 3)) request_bytes.push_back(random_digit());
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_E || b == CHAR_MINUS || (b >= CHAR_ZERO && b <= "9"));
            request_bytes.push_back(b);
         end
         2: begin
            // Bad byte inside a string length.
            repeat ($urandom_range(1, 3)) request_bytes.push_back(random_digit());
            do b = 8'($urandom_range(0, 255));
            while (b == CHAR_COLON || (b >= CHAR_ZERO && b <= "9"));
            request_bytes.push_back(b);
         end
         3: begin
            // One container more than the stack holds.
            repeat (DEFAULT_MAX_DEPTH + 1) append_open();
         end
         default: begin
            // The largest length that fits, then one more digit pushes it over.
            append_text($sformatf("%0d", (64'd1 << DEFAULT_LENGTH_BITS) - 64'd1));
            request_bytes.push_back(random_digit());
         end
      endcase
      repeat (20) request_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // The receiver switches between styles of back-pressure: always ready, ready on a
   // coin toss, and alternating runs of ready and stalled cycles.
   stall_style_type stall_style = ALWAYS_READY;
   int unsigned     style_left  = 0;
   int unsigned     run_left    = 0;
   logic            run_ready   = 1'b1;

   always @(negedge clock) begin
      if (style_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 2));
         style_left  = $urandom_range(20, 300);
      end else begin
         style_left--;
      end
      case (stall_style)
         ALWAYS_READY: rsp_tready <= 1'b1;
         COIN_READY:   rsp_tready <= ($urandom_range(0, 9) < 7);
         default: begin
            if (run_left == 0) begin
               run_ready = ~run_ready;
               run_left  = $urandom_range(1, 12);
            end
            run_left--;
            rsp_tready <= run_ready;
         end
      endcase
   end

   // The sender offers requests in bursts of random length with random gaps between
   // them. Inputs change only at falling edges; acceptance is judged at rising edges.
   initial begin
      int unsigned next_index;
      int unsigned burst_left;
      int unsigned gap_left;
      int unsigned drain;
      append_directed();
      build_document_stream(RANDOM_BYTES);
      append_breaking_tail();

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      next_index = 0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
      while (next_index < request_bytes.size()) begin
         @(negedge clock);
         if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= request_bytes[next_index];
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            next_index++;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Wait for every predicted result, then a little longer so that any stray result
      // from the halted block would still be caught.
      drain = 0;
      while (pending_results != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_results != 0) begin
         $display("%0t: %0d expected results never arrived", $realtime, pending_results);
      end

      if (mismatches == 0 && pending_results == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run did not finish in time", $realtime);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/btt_pkg.sv
rtl/bencode_to_text_transducer.sv
rtl/btt_checker.sv
test/bencode_text_checker.sv
test/bencode_to_text_transducer_tb.sv
